// File: design/idba_pkg.sv
// Shared constants, types and interval helpers for the double-booking admission block.
package idba_pkg;

  localparam int unsigned BookingDepth = 32;
  localparam int unsigned SegmentDepth = 64;
  localparam int unsigned TimeWidth    = 32;

  localparam int unsigned BkAddrW  = $clog2(BookingDepth);
  localparam int unsigned SgAddrW  = $clog2(SegmentDepth);
  localparam int unsigned BkCntW   = $clog2(BookingDepth + 1);
  localparam int unsigned SgCntW   = $clog2(SegmentDepth + 1);
  localparam int unsigned ScanCntW = (BkCntW > SgCntW) ? BkCntW : SgCntW;
  localparam int unsigned SumW     = ((BkCntW > SgCntW) ? BkCntW : SgCntW) + 1;
  localparam int unsigned EntryW   = 2 * TimeWidth;

  typedef logic [TimeWidth-1:0] time_t;

  typedef enum logic [1:0] {
    StAccept  = 2'd0,
    StTriple  = 2'd1,
    StFull    = 2'd2,
    StInvalid = 2'd3
  } status_e;

  typedef struct packed {
    logic               we;
    logic [BkAddrW-1:0] waddr;
    logic [EntryW-1:0]  wdata;
    logic [BkAddrW-1:0] raddr;
  } bk_req_t;

  typedef struct packed {
    logic               we;
    logic [SgAddrW-1:0] waddr;
    logic [EntryW-1:0]  wdata;
    logic [SgAddrW-1:0] raddr;
  } sg_req_t;

  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [BkCntW-1:0] bookings;
    logic [SgCntW-1:0] segments;
  } result_t;

  function automatic time_t time_max(time_t a, time_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic time_t time_min(time_t a, time_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic overlaps(time_t s0, time_t e0, time_t s1, time_t e1);
    return time_max(s0, s1) < time_min(e0, e1);
  endfunction

endpackage

// File: design/idba_ram.sv
// Simple dual-port synchronous RAM with one write port and a registered read port.
module idba_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/idba_ctrl.sv
// Admission sequencer: scans both tables, appends new segments and stores the booking.
module idba_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  idba_pkg::time_t         start_time_i,
  input  idba_pkg::time_t         end_time_i,
  output idba_pkg::bk_req_t       bk_req_o,
  input  logic [idba_pkg::EntryW-1:0] bk_rdata_i,
  output idba_pkg::sg_req_t       sg_req_o,
  input  logic [idba_pkg::EntryW-1:0] sg_rdata_i,
  output idba_pkg::result_t       res_o,
  input  logic                    res_ready_i
);
  import idba_pkg::*;

  typedef enum logic [2:0] {
    SIdle,
    SSegScan,
    SBkCount,
    SBkAppend,
    SDone
  } state_e;

  state_e              state_q, state_d;
  time_t               s_q, s_d, e_q, e_d;
  logic [BkCntW-1:0]   bfill_q, bfill_d;
  logic [SgCntW-1:0]   sfill_q, sfill_d;
  logic [ScanCntW-1:0] cnt_q, cnt_d;
  logic                chk_q, chk_d;
  logic [BkCntW-1:0]   fresh_q, fresh_d;
  status_e             status_q, status_d;

  logic  accept;
  logic  issue_sg, issue_bk;
  time_t sg_start, sg_end, bk_start, bk_end;
  logic  sg_hit, bk_hit;
  logic [SumW-1:0] need;

  assign accept   = in_valid_i && (state_q == SIdle);
  assign issue_sg = cnt_q < ScanCntW'(sfill_q);
  assign issue_bk = cnt_q < ScanCntW'(bfill_q);
  assign sg_start = sg_rdata_i[EntryW-1:TimeWidth];
  assign sg_end   = sg_rdata_i[TimeWidth-1:0];
  assign bk_start = bk_rdata_i[EntryW-1:TimeWidth];
  assign bk_end   = bk_rdata_i[TimeWidth-1:0];
  assign sg_hit   = overlaps(s_q, e_q, sg_start, sg_end);
  assign bk_hit   = overlaps(s_q, e_q, bk_start, bk_end);
  assign need     = SumW'(sfill_q) + SumW'(fresh_q);

  always_comb begin
    state_d  = state_q;
    s_d      = s_q;
    e_d      = e_q;
    bfill_d  = bfill_q;
    sfill_d  = sfill_q;
    cnt_d    = cnt_q;
    chk_d    = 1'b0;
    fresh_d  = fresh_q;
    status_d = status_q;
    bk_req_o.we    = 1'b0;
    bk_req_o.waddr = bfill_q[BkAddrW-1:0];
    bk_req_o.wdata = {s_q, e_q};
    bk_req_o.raddr = cnt_q[BkAddrW-1:0];
    sg_req_o.we    = 1'b0;
    sg_req_o.waddr = sfill_q[SgAddrW-1:0];
    sg_req_o.wdata = {time_max(s_q, bk_start), time_min(e_q, bk_end)};
    sg_req_o.raddr = cnt_q[SgAddrW-1:0];

    case (state_q)
      SIdle: begin
        if (accept) begin
          s_d   = start_time_i;
          e_d   = end_time_i;
          cnt_d = '0;
          if (start_time_i >= end_time_i) begin
            status_d = StInvalid;
            state_d  = SDone;
          end else begin
            state_d = SSegScan;
          end
        end
      end
      SSegScan: begin
        if (chk_q && sg_hit) begin
          status_d = StTriple;
          state_d  = SDone;
        end else if (issue_sg) begin
          cnt_d = cnt_q + 1'b1;
          chk_d = 1'b1;
        end else if (!chk_q) begin
          cnt_d   = '0;
          fresh_d = '0;
          state_d = SBkCount;
        end
      end
      SBkCount: begin
        if (chk_q && bk_hit) begin
          fresh_d = fresh_q + 1'b1;
        end
        if (issue_bk) begin
          cnt_d = cnt_q + 1'b1;
          chk_d = 1'b1;
        end else if (!chk_q) begin
          cnt_d = '0;
          if ((bfill_q == BkCntW'(BookingDepth)) || (need > SumW'(SegmentDepth))) begin
            status_d = StFull;
            state_d  = SDone;
          end else begin
            state_d = SBkAppend;
          end
        end
      end
      SBkAppend: begin
        if (chk_q && bk_hit && (sfill_q < SgCntW'(SegmentDepth))) begin
          sg_req_o.we = 1'b1;
          sfill_d     = sfill_q + 1'b1;
        end
        if (issue_bk) begin
          cnt_d = cnt_q + 1'b1;
          chk_d = 1'b1;
        end else if (!chk_q) begin
          bk_req_o.we = 1'b1;
          bfill_d     = bfill_q + 1'b1;
          status_d    = StAccept;
          state_d     = SDone;
        end
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      bfill_q  <= '0;
      sfill_q  <= '0;
      cnt_q    <= '0;
      chk_q    <= 1'b0;
      fresh_q  <= '0;
      status_q <= StAccept;
    end else begin
      state_q  <= state_d;
      bfill_q  <= bfill_d;
      sfill_q  <= sfill_d;
      cnt_q    <= cnt_d;
      chk_q    <= chk_d;
      fresh_q  <= fresh_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    e_q <= e_d;
  end

  assign in_stall_o      = (state_q != SIdle);
  assign res_o.valid     = (state_q == SDone);
  assign res_o.status    = status_q;
  assign res_o.bookings  = bfill_q;
  assign res_o.segments  = sfill_q;

  a_bfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bfill_q <= BkCntW'(BookingDepth))
    else $error("Booking count exceeds the table depth.");

  a_sfill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sfill_q <= SgCntW'(SegmentDepth))
    else $error("Segment count exceeds the table depth.");

  a_bk_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_req_o.we |=> (bfill_q == $past(bfill_q) + 1'b1) && (state_q == SDone)
                    && (status_q == StAccept))
    else $error("Booking store did not complete an acceptance.");

  a_sg_only_append: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sg_req_o.we |-> (state_q == SBkAppend))
    else $error("Segment write outside the append pass.");

  a_no_change_on_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SDone) && (status_q != StAccept) |-> $stable(bfill_q) && $stable(sfill_q))
    else $error("Fill counts changed on a rejected request.");

endmodule

// File: design/interval_double_booking_admission.sv
// Top level of the interval double-booking admission block with its two tables.
//
//   channel | direction | handshake                | word
//   in      | input     | in_valid_i / in_stall_o   | start_time_i, end_time_i
//   out     | output    | out_valid_o / out_stall_i | status_o, bookings_held_o, segments_held_o
//
// An invalid interval goes from the idle state straight to the done state and on into the
// output register once that register is free, and the controller then returns to idle.
// Table passes read stored entries one at a time through each memory's single read port;
// an admitted request makes a segment scan, a booking count pass and a booking append pass.
// Reset clears the fill counts; table contents are not cleared and need no sweep.
// One request is in work at a time; the next is accepted while a result waits in the
// output register, and a stalled result holds the finishing request in its last state.
module interval_double_booking_admission (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  idba_pkg::time_t             start_time_i,
  input  idba_pkg::time_t             end_time_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [idba_pkg::BkCntW-1:0] bookings_held_o,
  output logic [idba_pkg::SgCntW-1:0] segments_held_o
);
  import idba_pkg::*;

  bk_req_t             bk_req;
  sg_req_t             sg_req;
  logic [EntryW-1:0]   bk_rdata, sg_rdata;
  result_t             res;
  logic                res_ready, load;
  logic                out_valid_q, out_valid_d;
  status_e             status_q;
  logic [BkCntW-1:0]   bookings_q;
  logic [SgCntW-1:0]   segments_q;

  idba_ram #(
    .Depth (BookingDepth),
    .Width (EntryW)
  ) u_bk_ram (
    .clk_i   (clk_i),
    .we_i    (bk_req.we),
    .waddr_i (bk_req.waddr),
    .wdata_i (bk_req.wdata),
    .raddr_i (bk_req.raddr),
    .rdata_o (bk_rdata)
  );

  idba_ram #(
    .Depth (SegmentDepth),
    .Width (EntryW)
  ) u_sg_ram (
    .clk_i   (clk_i),
    .we_i    (sg_req.we),
    .waddr_i (sg_req.waddr),
    .wdata_i (sg_req.wdata),
    .raddr_i (sg_req.raddr),
    .rdata_o (sg_rdata)
  );

  idba_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_time_i (start_time_i),
    .end_time_i   (end_time_i),
    .bk_req_o     (bk_req),
    .bk_rdata_i   (bk_rdata),
    .sg_req_o     (sg_req),
    .sg_rdata_i   (sg_rdata),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  assign res_ready   = !out_valid_q || !out_stall_i;
  assign load        = res.valid && res_ready;
  assign out_valid_d = load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      status_q   <= res.status;
      bookings_q <= res.bookings;
      segments_q <= res.segments;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign bookings_held_o = bookings_q;
  assign segments_held_o = segments_q;

endmodule
